### rtl/grmc_pkg.sv
// Shared types, constants and helper functions of the grid ray-march column block.
package grmc_pkg;

    // Register indexes of the configuration port
    localparam logic [3:0] REG_SCREEN_WIDTH  = 4'd0;
    localparam logic [3:0] REG_SCREEN_HEIGHT = 4'd1;
    localparam logic [3:0] REG_FIELD_OF_VIEW = 4'd2;
    localparam logic [3:0] REG_MARCH_LIMIT   = 4'd3;
    localparam logic [3:0] REG_MAP_ROWS_A    = 4'd4;
    localparam logic [3:0] REG_MAP_ROWS_B    = 4'd5;
    localparam logic [3:0] REG_MAP_ROWS_C    = 4'd6;
    localparam logic [3:0] REG_MAP_ROWS_D    = 4'd7;

    // Reset values of the registers
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd1920;
    localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd1080;
    localparam logic [15:0] RST_FIELD_OF_VIEW = 16'd8192;
    localparam logic [7:0]  RST_MARCH_LIMIT   = 8'd160;

    // One cell is 163840 track units (2^15 * 5)
    localparam int CELL_SCALE  = 163840;
    localparam int CELL_SHIFT  = 15;
    localparam int RECIP_FIVE  = 205;
    localparam int RECIP_SHIFT = 10;
    localparam int POS_SCALE   = 40;
    localparam int NEAR_STEPS  = 20;

    // Q30 value of two pi, used when building the sine table
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    localparam int BASE_W  = 22;
    localparam int TRACK_W = 25;
    localparam int TRIG_W  = 16;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] view_angle;
        logic [11:0] column;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] ceiling_row;
        logic [14:0]        floor_row;
        logic [7:0]         wall_red;
        logic [7:0]         wall_green;
        logic [7:0]         wall_blue;
        logic [7:0]         step_count;
        logic               left_map;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  index;
        logic [63:0] value;
    } t_cfg_write;

    typedef struct packed {
        logic [11:0]  screen_width;
        logic [10:0]  screen_height;
        logic [15:0]  field_of_view;
        logic [7:0]   march_limit;
        logic [255:0] wall_map;
    } t_cfg;

    // Ray handed from the front to the back: start point and per-step increment
    typedef struct packed {
        logic [BASE_W-1:0]        base_x;
        logic [BASE_W-1:0]        base_y;
        logic signed [TRIG_W-1:0] step_x;
        logic signed [TRIG_W-1:0] step_y;
    } t_ray;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_DIV_GO,
        FR_DIV_WAIT,
        FR_TRIG,
        FR_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MARCH,
        BK_MUL,
        BK_DIV,
        BK_WAIT,
        BK_OUT
    } t_back_state;

    // Base wall colour {red, green, blue} from the parity of the final cell
    function automatic logic [23:0] base_colour(input logic [1:0] sel);
        logic [23:0] rgb;
        case (sel)
            2'd0:    rgb = {8'd139, 8'd69,  8'd19};
            2'd1:    rgb = {8'd70,  8'd130, 8'd180};
            2'd2:    rgb = {8'd147, 8'd112, 8'd219};
            default: rgb = {8'd128, 8'd128, 8'd128};
        endcase
        return rgb;
    endfunction

    // Cell of an in-map coordinate; points up to one cell below zero count as cell 0
    function automatic logic [3:0] cell_index(input logic signed [TRACK_W-1:0] p);
        logic [6:0]  q;
        logic [14:0] prod;
        q    = p[21:CELL_SHIFT];
        prod = 15'(q) * 15'(RECIP_FIVE);
        return (p > 0) ? prod[13:RECIP_SHIFT] : 4'd0;
    endfunction

    // Odd parity of the cell magnitude of any coordinate
    function automatic logic cell_odd(input logic signed [TRACK_W-1:0] p);
        logic [TRACK_W-1:0] mag;
        logic [8:0]         q;
        logic [16:0]        prod;
        mag  = p[TRACK_W-1] ? TRACK_W'(-p) : TRACK_W'(p);
        q    = mag[23:CELL_SHIFT];
        prod = 17'(q) * 17'(RECIP_FIVE);
        return prod[RECIP_SHIFT];
    endfunction

endpackage

### rtl/grmc_chan_if.sv
// Valid/ready channel carrying one payload of a given type.
interface grmc_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/grmc_div.sv
// Restoring divider, one quotient bit per cycle.
module grmc_div #(
    parameter int NW = 20,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        fits;

    // Trial subtraction of the divisor from the shifted remainder
    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
                r_quo <= {r_quo[NW-2:0], fits};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

### rtl/grmc_front.sv
// Front end: ray angle from column, sine and cosine lookup, ray set-up.
module grmc_front #(
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  grmc_pkg::t_cfg       i_cfg,
    grmc_chan_if.sink            i_in,
    grmc_chan_if.source          o_ray
);
    localparam int TRIG_N  = 1 << TRIG_TABLE_BITS;
    localparam int QUARTER = TRIG_N / 4;
    localparam int EXT_W   = ANGLE_BITS + TRIG_TABLE_BITS;
    localparam int AMASK   = (1 << ANGLE_BITS) - 1;

    // One quarter-turn sine entry in Q1.14 from a truncated Taylor series
    function automatic logic [15:0] quarter_sine(input int unsigned r);
        logic [63:0] theta;
        logic [63:0] sq;
        logic [63:0] term;
        logic [63:0] sum;
        theta = (64'(r) * grmc_pkg::TWO_PI_Q30) >> TRIG_TABLE_BITS;
        sq    = (theta * theta) >> 30;
        term  = theta;
        sum   = theta;
        for (int n = 1; n < 9; n++) begin
            term = ((term * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return 16'((sum + 64'd32768) >> 16);
    endfunction

    // Full-turn table folded out of the first quarter
    function automatic logic [TRIG_N*16-1:0] build_rom();
        logic [TRIG_N*16-1:0] rom;
        logic signed [15:0]   v;
        int                   q;
        int                   r;
        rom = '0;
        for (int k = 0; k < TRIG_N; k++) begin
            q = k / QUARTER;
            r = k % QUARTER;
            v = ((q % 2) == 1) ? quarter_sine(QUARTER - r) : quarter_sine(r);
            rom[k*16 +: 16] = ((q / 2) % 2 == 1) ? -v : v;
        end
        return rom;
    endfunction

    localparam logic [TRIG_N*16-1:0] SINE_ROM = build_rom();

    grmc_pkg::t_front_state r_state, n_state;
    grmc_pkg::t_in_item     r_item;
    grmc_pkg::t_ray         r_ray;
    logic [TRIG_TABLE_BITS-1:0] r_index;

    logic [15:0]                 fov_m;
    logic [11:0]                 width_eff;
    logic                        div_start;
    logic                        div_done;
    logic [27:0]                 div_quo;
    logic [ANGLE_BITS-1:0]       angle;
    logic [EXT_W-1:0]            angle_ext;
    logic [TRIG_TABLE_BITS-1:0]  index;
    logic [TRIG_TABLE_BITS-1:0]  cos_index;

    // Effective registers and the angle sum
    always_comb begin
        fov_m     = i_cfg.field_of_view & 16'(AMASK);
        width_eff = (i_cfg.screen_width == 12'd0) ? 12'd1 : i_cfg.screen_width;
        angle     = r_item.view_angle[ANGLE_BITS-1:0] - ANGLE_BITS'(fov_m >> 1)
                    + div_quo[ANGLE_BITS-1:0];
        angle_ext = EXT_W'(angle) << TRIG_TABLE_BITS;
        index     = TRIG_TABLE_BITS'(angle_ext >> ANGLE_BITS);
        cos_index = r_index + TRIG_TABLE_BITS'(QUARTER);
    end

    grmc_div #(.NW(28), .DW(12)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (28'(r_item.column) * 28'(fov_m)),
        .i_den   (width_eff),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Next state and handshake outputs
    always_comb begin
        n_state     = r_state;
        div_start   = 1'b0;
        i_in.ready  = 1'b0;
        o_ray.valid = 1'b0;
        case (r_state)
            grmc_pkg::FR_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) n_state = grmc_pkg::FR_DIV_GO;
            end
            grmc_pkg::FR_DIV_GO: begin
                div_start = 1'b1;
                n_state   = grmc_pkg::FR_DIV_WAIT;
            end
            grmc_pkg::FR_DIV_WAIT: begin
                if (div_done) n_state = grmc_pkg::FR_TRIG;
            end
            grmc_pkg::FR_TRIG: begin
                n_state = grmc_pkg::FR_PUSH;
            end
            grmc_pkg::FR_PUSH: begin
                o_ray.valid = 1'b1;
                if (o_ray.ready) n_state = grmc_pkg::FR_IDLE;
            end
            default: n_state = grmc_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grmc_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the item, then the table index, then the ray
    always_ff @(posedge i_clk) begin
        if (r_state == grmc_pkg::FR_IDLE && i_in.valid) begin
            r_item <= i_in.data;
        end
        if (r_state == grmc_pkg::FR_DIV_WAIT && div_done) begin
            r_index <= index;
        end
        if (r_state == grmc_pkg::FR_TRIG) begin
            r_ray.base_x <= grmc_pkg::BASE_W'(r_item.pos_x)
                            * grmc_pkg::BASE_W'(grmc_pkg::POS_SCALE);
            r_ray.base_y <= grmc_pkg::BASE_W'(r_item.pos_y)
                            * grmc_pkg::BASE_W'(grmc_pkg::POS_SCALE);
            r_ray.step_x <= SINE_ROM[{r_index, 4'b0} +: 16];
            r_ray.step_y <= SINE_ROM[{cos_index, 4'b0} +: 16];
        end
    end

    assign o_ray.data = r_ray;
endmodule

### rtl/grmc_fifo.sv
// Two-entry queue between the front and the back.
module grmc_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grmc_chan_if.sink   i_push,
    grmc_chan_if.source o_pop
);
    grmc_pkg::t_ray r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    logic           push;
    logic           pop;

    always_comb begin
        i_push.ready = (r_count != 2'd2);
        o_pop.valid  = (r_count != 2'd0);
        o_pop.data   = r_mem[r_rd];
        push         = i_push.valid && i_push.ready;
        pop          = o_pop.valid && o_pop.ready;
    end

    // Store on push
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_push.data;
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end
endmodule

### rtl/grmc_back.sv
// Back end: tenth-cell march over the wall map, slice rows and shading.
module grmc_back #(
    parameter int MAP_SIDE = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  grmc_pkg::t_cfg i_cfg,
    grmc_chan_if.sink      i_ray,
    grmc_chan_if.source    o_res
);
    localparam int TW = grmc_pkg::TRACK_W;
    localparam logic signed [TW-1:0] NEG_EDGE = -TW'(grmc_pkg::CELL_SCALE);
    localparam logic signed [TW-1:0] MAP_EDGE = TW'(MAP_SIDE * grmc_pkg::CELL_SCALE);

    grmc_pkg::t_back_state r_state, n_state;
    grmc_pkg::t_ray        r_ray;
    grmc_pkg::t_out_item   r_out;
    logic                  r_ov;
    logic signed [TW-1:0]  r_xp, r_yp, r_fx, r_fy;
    logic [7:0]            r_k, r_steps, r_shade;
    logic                  r_left;
    logic signed [20:0]    r_num;

    logic [7:0]            lim;
    logic signed [TW-1:0]  sx, sy, nx, ny;
    logic [7:0]            k_next;
    logic                  leaves;
    logic                  wall;
    logic [23:0]           rgb;
    logic                  div_start;
    logic                  ceil_done, red_done, green_done, blue_done;
    logic [19:0]           ceil_quo, red_quo, green_quo, blue_quo;
    logic [19:0]           num_mag;
    logic signed [15:0]    ceil_row;
    logic                  load_out;

    // One march step and its tests
    always_comb begin
        lim    = (i_cfg.march_limit == 8'd0) ? 8'd1 : i_cfg.march_limit;
        sx     = TW'(r_ray.step_x);
        sy     = TW'(r_ray.step_y);
        nx     = r_xp + sx;
        ny     = r_yp + sy;
        k_next = r_k + 8'd1;
        leaves = (nx <= NEG_EDGE) || (nx >= MAP_EDGE) || (ny <= NEG_EDGE) || (ny >= MAP_EDGE);
        wall   = i_cfg.wall_map[{grmc_pkg::cell_index(nx), grmc_pkg::cell_index(ny)}];
        rgb    = grmc_pkg::base_colour({grmc_pkg::cell_odd(r_fx), grmc_pkg::cell_odd(r_fy)});
        num_mag  = r_num[20] ? 20'(-r_num) : 20'(r_num);
        ceil_row = r_num[20] ? -16'(ceil_quo) : 16'(ceil_quo);
    end

    grmc_div #(.NW(20), .DW(9)) u_div_ceil (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num_mag), .i_den({r_steps, 1'b0}),
        .o_done(ceil_done), .o_quo(ceil_quo)
    );
    grmc_div #(.NW(20), .DW(9)) u_div_red (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(20'(rgb[23:16]) * 20'(r_shade)), .i_den({1'b0, lim}),
        .o_done(red_done), .o_quo(red_quo)
    );
    grmc_div #(.NW(20), .DW(9)) u_div_green (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(20'(rgb[15:8]) * 20'(r_shade)), .i_den({1'b0, lim}),
        .o_done(green_done), .o_quo(green_quo)
    );
    grmc_div #(.NW(20), .DW(9)) u_div_blue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(20'(rgb[7:0]) * 20'(r_shade)), .i_den({1'b0, lim}),
        .o_done(blue_done), .o_quo(blue_quo)
    );

    // Next state and handshake outputs
    always_comb begin
        n_state     = r_state;
        div_start   = 1'b0;
        load_out    = 1'b0;
        i_ray.ready = 1'b0;
        case (r_state)
            grmc_pkg::BK_IDLE: begin
                i_ray.ready = 1'b1;
                if (i_ray.valid) n_state = grmc_pkg::BK_MARCH;
            end
            grmc_pkg::BK_MARCH: begin
                if (leaves || wall || k_next == lim) n_state = grmc_pkg::BK_MUL;
            end
            grmc_pkg::BK_MUL: begin
                n_state = grmc_pkg::BK_DIV;
            end
            grmc_pkg::BK_DIV: begin
                div_start = 1'b1;
                n_state   = grmc_pkg::BK_WAIT;
            end
            grmc_pkg::BK_WAIT: begin
                if (ceil_done) n_state = grmc_pkg::BK_OUT;
            end
            grmc_pkg::BK_OUT: begin
                if (!r_ov || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = grmc_pkg::BK_IDLE;
                end
            end
            default: n_state = grmc_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grmc_pkg::BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // March, final point, products and results
    always_ff @(posedge i_clk) begin
        case (r_state)
            grmc_pkg::BK_IDLE: begin
                if (i_ray.valid) begin
                    r_ray  <= i_ray.data;
                    r_xp   <= TW'({1'b0, i_ray.data.base_x});
                    r_yp   <= TW'({1'b0, i_ray.data.base_y});
                    r_k    <= 8'd0;
                    r_left <= 1'b0;
                end
            end
            grmc_pkg::BK_MARCH: begin
                r_xp <= nx;
                r_yp <= ny;
                r_k  <= k_next;
                if (leaves) begin
                    r_left  <= 1'b1;
                    r_steps <= lim;
                end else begin
                    r_steps <= k_next;
                end
            end
            grmc_pkg::BK_MUL: begin
                r_fx    <= TW'({1'b0, r_ray.base_x})
                           + TW'($signed({1'b0, r_steps})) * TW'(r_ray.step_x);
                r_fy    <= TW'({1'b0, r_ray.base_y})
                           + TW'($signed({1'b0, r_steps})) * TW'(r_ray.step_y);
                r_num   <= $signed({1'b0, i_cfg.screen_height})
                           * ($signed({1'b0, r_steps}) - 9'(grmc_pkg::NEAR_STEPS));
                r_shade <= lim - r_steps;
            end
            // Quotients hold until the next start, so load only once the slot is free
            grmc_pkg::BK_OUT: begin
                if (load_out) begin
                    r_out.ceiling_row <= ceil_row;
                    r_out.floor_row   <= 15'(16'(i_cfg.screen_height) - ceil_row);
                    r_out.wall_red    <= red_quo[7:0];
                    r_out.wall_green  <= green_quo[7:0];
                    r_out.wall_blue   <= blue_quo[7:0];
                    r_out.step_count  <= r_steps;
                    r_out.left_map    <= r_left;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    // The step counter stays below the limit while marching
    a_march_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == grmc_pkg::BK_MARCH) |-> (r_k < lim))
        else $error("march step counter reached the limit");

    // Dividers report only while their results are awaited
    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ceil_done |-> (r_state == grmc_pkg::BK_WAIT))
        else $error("divider finished outside the wait state");

    // All four dividers finish together
    a_div_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ceil_done |-> (red_done && green_done && blue_done))
        else $error("colour dividers out of step with the ceiling divider");
endmodule

### rtl/grid_ray_march_column_top.sv
// Top level of the grid ray-march column block: registers, front, queue and back.
//
// Each input item is one screen column; it yields one result with the wall slice rows, the
// shaded colour, the step count and the left-map flag. The front sets up the ray of one item at
// a time, using its 28-bit bit-serial divider for the column angle. The back then marches one
// tenth-cell step per cycle, up to the march limit (at most 255), and then forms the final
// products and runs its divider bank. A two-entry queue lets the front set up the next ray
// while the back marches, and an output register holds a finished result while the back goes
// on. Register writes are taken in any cycle and must only be made while idle.
module grid_ray_march_column_top #(
    parameter int MAP_SIDE        = 16,
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grmc_chan_if.sink   i_in,
    grmc_chan_if.source o_out,
    grmc_chan_if.sink   i_cfg
);
    grmc_pkg::t_cfg r_cfg;

    grmc_chan_if #(.T(grmc_pkg::t_ray)) w_ray_q ();
    grmc_chan_if #(.T(grmc_pkg::t_ray)) w_ray_b ();

    assign i_cfg.ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= grmc_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height <= grmc_pkg::RST_SCREEN_HEIGHT;
            r_cfg.field_of_view <= grmc_pkg::RST_FIELD_OF_VIEW;
            r_cfg.march_limit   <= grmc_pkg::RST_MARCH_LIMIT;
            r_cfg.wall_map      <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                grmc_pkg::REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg.data.value[11:0];
                grmc_pkg::REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg.data.value[10:0];
                grmc_pkg::REG_FIELD_OF_VIEW: r_cfg.field_of_view <= i_cfg.data.value[15:0];
                grmc_pkg::REG_MARCH_LIMIT:   r_cfg.march_limit   <= i_cfg.data.value[7:0];
                grmc_pkg::REG_MAP_ROWS_A:    r_cfg.wall_map[63:0]    <= i_cfg.data.value;
                grmc_pkg::REG_MAP_ROWS_B:    r_cfg.wall_map[127:64]  <= i_cfg.data.value;
                grmc_pkg::REG_MAP_ROWS_C:    r_cfg.wall_map[191:128] <= i_cfg.data.value;
                grmc_pkg::REG_MAP_ROWS_D:    r_cfg.wall_map[255:192] <= i_cfg.data.value;
                default: begin
                end
            endcase
        end
    end

    grmc_front #(
        .ANGLE_BITS      (ANGLE_BITS),
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_ray   (w_ray_q)
    );

    grmc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ray_q),
        .o_pop   (w_ray_b)
    );

    grmc_back #(
        .MAP_SIDE (MAP_SIDE)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ray   (w_ray_b),
        .o_res   (o_out)
    );
endmodule

### tb/grid_ray_march_column_top_test.sv
// Self-checking testbench of the grid ray-march column block: directed table, then random columns.
module grid_ray_march_column_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] REG_SPARE   = 4'd9;
    localparam int         SETTLE_CYC  = 400;
    localparam int         RAND_PHASES = 10;
    localparam int         PHASE_ITEMS = 95;

    // Slice of any ray that leaves the map, under the reset settings
    localparam grmc_pkg::t_out_item EXIT_AT_RESET = '{ceiling_row: 16'sd472, floor_row: 15'd608,
        wall_red: 8'd0, wall_green: 8'd0, wall_blue: 8'd0, step_count: 8'd160, left_map: 1'b1};

    typedef struct packed {
        grmc_pkg::t_in_item item;
        logic               typed;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   fails;
    bit   burst;

    grmc_chan_if #(.T(grmc_pkg::t_in_item))   in_ch ();
    grmc_chan_if #(.T(grmc_pkg::t_out_item))  out_ch ();
    grmc_chan_if #(.T(grmc_pkg::t_cfg_write)) cfg_ch ();

    grid_ray_march_column_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Shadow of the block's registers and its sine table
    logic [11:0] sh_width;
    logic [10:0] sh_height;
    logic [15:0] sh_fov;
    logic [7:0]  sh_limit;
    logic [63:0] sh_map [4];
    int          sine_tab [1024];

    grmc_pkg::t_out_item slices_due [$];

    // Directed table: reset-setting rows first, then rows under the extreme settings
    t_row dir_rows [24] = '{
        '{'{16'h8000, 16'h8000, 16'h0000, 12'd0},    1'b1},
        '{'{16'h8000, 16'h8000, 16'h4000, 12'd960},  1'b1},
        '{'{16'h8000, 16'h8000, 16'h8000, 12'd1919}, 1'b1},
        '{'{16'h8000, 16'h8000, 16'hC000, 12'd4095}, 1'b1},
        '{'{16'h8000, 16'h8000, 16'hFFFF, 12'd1},    1'b1},
        '{'{16'h0000, 16'h0000, 16'h0000, 12'd0},    1'b0},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd4095}, 1'b0},
        '{'{16'h0000, 16'hFFFF, 16'hA000, 12'd2000}, 1'b0},
        '{'{16'hFFFF, 16'h0000, 16'h2000, 12'd100},  1'b0},
        '{'{16'h0800, 16'h0800, 16'hE000, 12'd0},    1'b0},
        '{'{16'h0000, 16'h0000, 16'h0000, 12'd0},    1'b0},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd4095}, 1'b0},
        '{'{16'h8000, 16'h8000, 16'h1234, 12'd7},    1'b0},
        '{'{16'h1000, 16'hF000, 16'h6000, 12'd2047}, 1'b0},
        '{'{16'h0000, 16'h0000, 16'h0000, 12'd0},    1'b0},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd4095}, 1'b0},
        '{'{16'h8000, 16'h4000, 16'h8000, 12'd3000}, 1'b0},
        '{'{16'h0400, 16'h0400, 16'h2000, 12'd5},    1'b0},
        '{'{16'h0000, 16'h0000, 16'h0000, 12'd0},    1'b0},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd4095}, 1'b0},
        '{'{16'h7FFF, 16'h8001, 16'h4000, 12'd0},    1'b0},
        '{'{16'h5555, 16'hAAAA, 16'h5555, 12'hAAA},  1'b0},
        '{'{16'hAAAA, 16'h5555, 16'hAAAA, 12'h555},  1'b0},
        '{'{16'h8000, 16'h8000, 16'hC000, 12'd4095}, 1'b0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #20ms;
        $display("grid_ray_march_column_top verification failed");
        $finish;
    end

    // Build the quarter-wave sine table and mirror it over the full turn
    function automatic int quarter_wave(int unsigned r);
        longint unsigned theta, sq, term, acc;
        theta = (longint'(r) * grmc_pkg::TWO_PI_Q30) >> 10;
        sq    = (theta * theta) >> 30;
        term  = theta;
        acc   = theta;
        for (int n = 1; n < 9; n++) begin
            term = ((term * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= term;
            else acc += term;
        end
        return int'((acc + 64'd32768) >> 16);
    endfunction

    function automatic void fill_sine();
        int v;
        for (int k = 0; k < 1024; k++) begin
            v = ((k / 256) % 2 == 1) ? quarter_wave(256 - k % 256) : quarter_wave(k % 256);
            sine_tab[k] = ((k / 256) >= 2) ? -v : v;
        end
    endfunction

    function automatic bit outside_map(longint p);
        return p <= -longint'(grmc_pkg::CELL_SCALE) || p >= 16 * longint'(grmc_pkg::CELL_SCALE);
    endfunction

    function automatic bit even_cell(longint p);
        longint mag;
        mag = (p < 0) ? -p : p;
        return ((mag / grmc_pkg::CELL_SCALE) % 2) == 0;
    endfunction

    function automatic bit wall_at(longint px, longint py);
        int row, col;
        row = (px > 0) ? int'(px / grmc_pkg::CELL_SCALE) : 0;
        col = (py > 0) ? int'(py / grmc_pkg::CELL_SCALE) : 0;
        return sh_map[(row >> 2) & 3][((row & 3) * 16 + (col & 15)) & 63];
    endfunction

    // March one column and form its wall slice and shade
    function automatic grmc_pkg::t_out_item column_slice(grmc_pkg::t_in_item it);
        grmc_pkg::t_out_item res;
        longint      width, lim, h, sx, sy, bx, by, xp, yp, k, steps, ceil_r;
        logic [15:0] ang;
        int          idx, sel;
        logic [23:0] rgb;
        bit          hit, left;
        width = (sh_width == 0) ? 1 : longint'(sh_width);
        lim   = (sh_limit == 0) ? 1 : longint'(sh_limit);
        h     = longint'(sh_height);
        ang   = 16'(longint'(it.view_angle) - longint'(sh_fov >> 1)
                + (longint'(it.column) * longint'(sh_fov)) / width);
        idx   = int'(ang >> 6);
        sx    = sine_tab[idx];
        sy    = sine_tab[(idx + 256) % 1024];
        bx    = grmc_pkg::POS_SCALE * longint'(it.pos_x);
        by    = grmc_pkg::POS_SCALE * longint'(it.pos_y);
        k     = 0;
        hit   = 1'b0;
        left  = 1'b0;
        while (!hit && k < lim) begin
            k++;
            xp = bx + k * sx;
            yp = by + k * sy;
            if (outside_map(xp) || outside_map(yp)) begin
                hit  = 1'b1;
                left = 1'b1;
            end else if (wall_at(xp, yp)) begin
                hit = 1'b1;
            end
        end
        steps  = left ? lim : k;
        ceil_r = (h * (steps - grmc_pkg::NEAR_STEPS)) / (2 * steps);
        xp     = bx + steps * sx;
        yp     = by + steps * sy;
        sel    = even_cell(xp) ? (even_cell(yp) ? 0 : 1) : (even_cell(yp) ? 2 : 3);
        case (sel)
            0:       rgb = {8'd139, 8'd69, 8'd19};
            1:       rgb = {8'd70, 8'd130, 8'd180};
            2:       rgb = {8'd147, 8'd112, 8'd219};
            default: rgb = {8'd128, 8'd128, 8'd128};
        endcase
        res.ceiling_row = 16'(ceil_r);
        res.floor_row   = 15'(h - ceil_r);
        res.wall_red    = 8'(longint'(rgb[23:16]) * (lim - steps) / lim);
        res.wall_green  = 8'(longint'(rgb[15:8]) * (lim - steps) / lim);
        res.wall_blue   = 8'(longint'(rgb[7:0]) * (lim - steps) / lim);
        res.step_count  = 8'(steps);
        res.left_map    = left;
        return res;
    endfunction

    // Write one register and mirror it
    task automatic write_reg(logic [3:0] idx, logic [63:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            grmc_pkg::REG_SCREEN_WIDTH:  sh_width  = val[11:0];
            grmc_pkg::REG_SCREEN_HEIGHT: sh_height = val[10:0];
            grmc_pkg::REG_FIELD_OF_VIEW: sh_fov    = val[15:0];
            grmc_pkg::REG_MARCH_LIMIT:   sh_limit  = val[7:0];
            grmc_pkg::REG_MAP_ROWS_A:    sh_map[0] = val;
            grmc_pkg::REG_MAP_ROWS_B:    sh_map[1] = val;
            grmc_pkg::REG_MAP_ROWS_C:    sh_map[2] = val;
            grmc_pkg::REG_MAP_ROWS_D:    sh_map[3] = val;
            default: ;
        endcase
    endtask

    // Drain, let the block settle, then load a full setting
    task automatic load_setting(logic [11:0] w, logic [10:0] h, logic [15:0] fov,
                                logic [7:0] lim, logic [63:0] m0, logic [63:0] m1,
                                logic [63:0] m2, logic [63:0] m3);
        while (slices_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        write_reg(grmc_pkg::REG_SCREEN_WIDTH, 64'(w));
        write_reg(grmc_pkg::REG_SCREEN_HEIGHT, 64'(h));
        write_reg(grmc_pkg::REG_FIELD_OF_VIEW, 64'(fov));
        write_reg(grmc_pkg::REG_MARCH_LIMIT, 64'(lim));
        write_reg(grmc_pkg::REG_MAP_ROWS_A, m0);
        write_reg(grmc_pkg::REG_MAP_ROWS_B, m1);
        write_reg(grmc_pkg::REG_MAP_ROWS_C, m2);
        write_reg(grmc_pkg::REG_MAP_ROWS_D, m3);
        write_reg(REG_SPARE, {$urandom, $urandom});
    endtask

    // Offer one column after a random gap, or none in burst phases; queue what it should yield on transfer
    task automatic send_column(grmc_pkg::t_in_item it, bit typed);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        slices_due.insert(slices_due.size(), typed ? EXIT_AT_RESET : column_slice(it));
    endtask

    function automatic logic [63:0] random_map();
        logic [63:0] a, b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return a & b;
            1:       return a & b & {$urandom, $urandom};
            2:       return a;
            default: return '0;
        endcase
    endfunction

    // Stall the result side at random, with calm stretches
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = burst ? 0 : $urandom_range(0, 7);
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Compare each result transfer with the oldest slice due
    always @(posedge i_clk) begin
        grmc_pkg::t_out_item want, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (slices_due.size() == 0) begin
                $display("%t: unexpected result %p", $time, got);
                fails++;
            end else begin
                want = slices_due.pop_front();
                if (got.ceiling_row !== want.ceiling_row || got.floor_row !== want.floor_row
                    || got.wall_red !== want.wall_red || got.wall_green !== want.wall_green
                    || got.wall_blue !== want.wall_blue || got.step_count !== want.step_count
                    || got.left_map !== want.left_map) begin
                    $display("%t: slice mismatch expected %p actual %p", $time, want, got);
                    fails++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        grmc_pkg::t_in_item it;
        fails        = 0;
        burst        = 1'b0;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        sh_width     = grmc_pkg::RST_SCREEN_WIDTH;
        sh_height    = grmc_pkg::RST_SCREEN_HEIGHT;
        sh_fov       = grmc_pkg::RST_FIELD_OF_VIEW;
        sh_limit     = grmc_pkg::RST_MARCH_LIMIT;
        for (int i = 0; i < 4; i++) sh_map[i] = '0;
        fill_sine();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table, changing to extreme settings between groups
        for (int r = 0; r < 24; r++) begin
            if (r == 5 || r == 10 || r == 14 || r == 18) begin
                in_ch.valid <= 1'b0;
                case (r)
                    5:  load_setting(12'd0, 11'd2047, 16'hFFFF, 8'd255,
                                     '0, 64'h8000_0000_0000_0001, '0, 64'hFFFF_0000_0000_FFFF);
                    10: load_setting(12'd4095, 11'd0, 16'd0, 8'd0, '1, '1, '1, '1);
                    14: load_setting(12'd1, 11'd1, 16'd1, 8'd1,
                                     64'h0F0F_0F0F_0F0F_0F0F, '0, '0, '0);
                    default: load_setting(12'd640, 11'd480, 16'h4000, 8'd255,
                                          64'h8001_8001_8001_FFFF, 64'h8001_8001_8001_8001,
                                          64'h8001_8001_8001_8001, 64'hFFFF_8001_8001_8001);
                endcase
            end
            send_column(dir_rows[r].item, dir_rows[r].typed);
        end

        // Random phases: mostly walled maps under varied settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            in_ch.valid <= 1'b0;
            burst = (p % 3 == 2);
            load_setting((p == 0) ? 12'd4095 : 12'($urandom_range(0, 4095)),
                         (p == 1) ? 11'd2047 : 11'($urandom_range(0, 2047)),
                         16'($urandom), (p == 2) ? 8'd255 : 8'($urandom_range(0, 255)),
                         random_map(), random_map(), random_map(), random_map());
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                it.pos_x      = 16'($urandom);
                it.pos_y      = 16'($urandom);
                it.view_angle = 16'($urandom);
                it.column     = ($urandom_range(0, 7) == 0) ? 12'($urandom)
                                : 12'($urandom_range(0, (sh_width == 0) ? 0 : sh_width - 1));
                send_column(it, 1'b0);
            end
        end
        in_ch.valid <= 1'b0;
        burst = 1'b0;

        // Drain and let the block settle
        while (slices_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (fails == 0) begin
            $display("grid_ray_march_column_top verification clean");
        end else begin
            $display("grid_ray_march_column_top verification failed");
        end
        $finish;
    end

endmodule
